// File: sv/ctme_pkg.sv
// shared types and constants for the control input to midi events block
package ctme_pkg;

	localparam int INPUT_SLOTS = 32;
	// slot count is a power of two of at most 32, so the slot is the low index bits
	localparam int SLOT_W      = $clog2(INPUT_SLOTS);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int SAMPLE_W = 10;
	localparam int NUMBER_W = 11;
	localparam int VALUE_W  = 7;

	localparam logic [NUMBER_W-1:0] NUM_NRPN_MSB = 11'd101;
	localparam logic [NUMBER_W-1:0] NUM_NRPN_LSB = 11'd100;
	localparam logic [NUMBER_W-1:0] NUM_DATA_MSB = 11'd6;
	localparam logic [NUMBER_W-1:0] NUM_DATA_LSB = 11'd38;
	localparam logic [NUMBER_W-1:0] NUM_NONE     = 11'd0;

	typedef enum logic [1:0] {
		CFG_DEADBAND    = 2'd0,
		CFG_ACTIVE_BANK = 2'd1,
		CFG_INPUT_COUNT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MODE_OFF     = 3'd0,
		MODE_NOTE    = 3'd1,
		MODE_CC      = 3'd2,
		MODE_NRPN    = 3'd3,
		MODE_PROGRAM = 3'd4,
		MODE_SHIFTER = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NOTE = 2'd0,
		KIND_CC   = 2'd1,
		KIND_PROG = 2'd2
	} kind_t;

	typedef struct packed {
		logic [9:0] deadband;
		logic [3:0] active_bank;
		logic [5:0] input_count;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [6:0]          num_hi;
		logic [6:0]          num_lo;
		logic [4:0]          midi_channel;
		mode_t               mode;
		logic                is_analog;
		logic [4:0]          input_index;
	} item_t;

	// accepted reading waiting for message generation
	typedef struct packed {
		mode_t               mode;
		logic [4:0]          channel;
		logic [6:0]          fine;
		logic [6:0]          coarse;
		logic [SAMPLE_W-1:0] reading;
	} job_t;

	typedef struct packed {
		kind_t               kind;
		logic [4:0]          channel;
		logic [NUMBER_W-1:0] number;
		logic [VALUE_W-1:0]  value;
		logic                last;
	} msg_t;

endpackage

// File: sv/ctme_front.sv
// front end: per-input deadband filter and reading store, issues jobs
module ctme_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ctme_pkg::item_t in_item,
	input  ctme_pkg::cfg_t  cfg,
	output logic           push,
	output ctme_pkg::job_t  push_job,
	input  logic           queue_ready
);
	import ctme_pkg::*;

	logic [SAMPLE_W-1:0] prev_q [INPUT_SLOTS];
	logic [INPUT_SLOTS-1:0] rising_q;

	logic [SLOT_W-1:0]   slot;
	logic [SAMPLE_W-1:0] prv;
	logic [SAMPLE_W-1:0] rd;
	logic [SAMPLE_W:0]   rd_plus_thr;
	logic [SAMPLE_W:0]   prv_plus_thr;
	logic                pass;
	logic                new_rising;
	logic                take;
	logic                upd;
	logic                emits;

	assign slot     = in_item.input_index[SLOT_W-1:0];
	assign prv      = prev_q[slot];
	assign in_ready = queue_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		if (in_item.is_analog && in_item.mode != MODE_NRPN) begin
			rd = {3'b000, in_item.sample[SAMPLE_W-1:3]};
		end else begin
			rd = in_item.sample;
		end
		rd_plus_thr  = {1'b0, rd} + {1'b0, cfg.deadband};
		prv_plus_thr = {1'b0, prv} + {1'b0, cfg.deadband};
		new_rising   = rising_q[slot];
		pass         = 1'b0;
		if (!in_item.is_analog) begin
			pass = (rd != prv);
		end else if (rising_q[slot]) begin
			if (rd > prv) begin
				pass = 1'b1;
			end else if (rd_plus_thr < {1'b0, prv}) begin
				pass       = 1'b1;
				new_rising = 1'b0;
			end
		end else begin
			if (rd < prv) begin
				pass = 1'b1;
			end else if ({1'b0, rd} > prv_plus_thr) begin
				pass       = 1'b1;
				new_rising = 1'b1;
			end
		end
	end

	always_comb begin
		case (in_item.mode) inside
			MODE_NOTE, MODE_CC, MODE_NRPN, MODE_PROGRAM: emits = 1'b1;
			default:                                     emits = 1'b0;
		endcase
	end

	assign upd  = take && (in_item.mode != MODE_OFF) && pass;
	assign push = upd && emits;

	assign push_job.mode    = in_item.mode;
	assign push_job.channel = in_item.midi_channel;
	assign push_job.fine    = in_item.num_lo;
	assign push_job.coarse  = in_item.num_hi;
	assign push_job.reading = rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rising_q <= '0;
			for (int i = 0; i < INPUT_SLOTS; i++) begin
				prev_q[i] <= '0;
			end
		end else if (upd) begin
			prev_q[slot]   <= rd;
			rising_q[slot] <= new_rising;
		end
	end

endmodule

// File: sv/ctme_queue.sv
// short job queue between front end and message generator
module ctme_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ctme_pkg::job_t push_job,
	output logic          push_ready,
	input  logic          pop,
	output logic          head_valid,
	output ctme_pkg::job_t head_job
);
	import ctme_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/ctme_back.sv
// back end: each job to midi messages in an output reg, one per cycle unless stalled
module ctme_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  ctme_pkg::job_t head_job,
	output logic          pop,
	input  ctme_pkg::cfg_t cfg,
	output logic          out_valid,
	input  logic          out_ready,
	output ctme_pkg::msg_t out_msg
);
	import ctme_pkg::*;

	logic [1:0]          msg_idx_q;
	logic                out_valid_q;
	msg_t                out_msg_q;
	msg_t                msg;
	logic                load;
	logic [9:0]          bank_offset;
	logic [NUMBER_W-1:0] num;

	assign bank_offset = 10'(cfg.input_count) * 10'(cfg.active_bank);
	assign num         = NUMBER_W'(head_job.fine) + NUMBER_W'(bank_offset);

	always_comb begin
		msg.channel = head_job.channel;
		msg.kind    = KIND_CC;
		msg.number  = num;
		msg.value   = head_job.reading[VALUE_W-1:0];
		msg.last    = 1'b1;
		unique case (head_job.mode)
			MODE_NOTE: begin
				msg.kind = KIND_NOTE;
			end
			MODE_PROGRAM: begin
				msg.kind   = KIND_PROG;
				msg.number = NUM_NONE;
			end
			MODE_NRPN: begin
				msg.last = (msg_idx_q == 2'd3);
				unique case (msg_idx_q)
					2'd0: begin
						msg.number = NUM_NRPN_MSB;
						msg.value  = head_job.coarse;
					end
					2'd1: begin
						msg.number = NUM_NRPN_LSB;
						msg.value  = head_job.fine;
					end
					2'd2: begin
						msg.number = NUM_DATA_MSB;
						msg.value  = {4'b0000, head_job.reading[SAMPLE_W-1:VALUE_W]};
					end
					default: begin
						msg.number = NUM_DATA_LSB;
					end
				endcase
			end
			default: begin
				msg.kind = KIND_CC;
			end
		endcase
	end

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign pop       = load && msg.last;
	assign out_valid = out_valid_q;
	assign out_msg   = out_msg_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_msg_q <= msg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			msg_idx_q   <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				msg_idx_q   <= msg.last ? 2'd0 : msg_idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/control_input_to_midi_events_top.sv
// top level: config registers, front end, job queue and message generator
//
// channel  | dir | handshake           | payload
// ---------+-----+---------------------+------------------------------------------
// sample   | in  | s_tvalid / s_tready | s_tdata, s_tuser (is_analog)
// message  | out | m_tvalid / m_tready | m_tdata, m_tuser (msg_kind), m_tlast
// config   | in  | cfg_we              | cfg_index, cfg_data
//
// an item is filtered and its reading stored in the cycle it is accepted; a new item can
// be taken every cycle while the four-entry job queue has room
// the message generator emits one message per cycle unless stalled: one for note, control
// change and program change, four for nrpn; an nrpn job leaves the queue with its last one
// a stall on the message side holds the output register and backs up through the queue
// reset clears all stored readings and directions at once, no clearing pass
module control_input_to_midi_events_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// input_index[4:0], mode[7:5], midi_channel[12:8], num_lo[19:13],
	// num_hi[26:20], sample[36:27], zero fill[39:37]
	input  logic [39:0] s_tdata,
	// is_analog
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_channel[4:0], number[15:5], value[22:16], zero fill[23]
	output logic [23:0] m_tdata,
	// msg_kind[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import ctme_pkg::*;

	cfg_t  cfg_q;
	item_t item;
	job_t  push_job;
	job_t  head_job;
	msg_t  msg;
	logic  push;
	logic  queue_ready;
	logic  head_valid;
	logic  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband    <= 10'd2;
			cfg_q.active_bank <= 4'd0;
			cfg_q.input_count <= 6'd32;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEADBAND:    cfg_q.deadband    <= cfg_data;
				CFG_ACTIVE_BANK: cfg_q.active_bank <= cfg_data[3:0];
				CFG_INPUT_COUNT: cfg_q.input_count <= cfg_data[5:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	assign item.input_index  = s_tdata[4:0];
	assign item.mode         = mode_t'(s_tdata[7:5]);
	assign item.midi_channel = s_tdata[12:8];
	assign item.num_lo       = s_tdata[19:13];
	assign item.num_hi       = s_tdata[26:20];
	assign item.sample       = s_tdata[36:27];
	assign item.is_analog    = s_tuser;

	ctme_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_item     (item),
		.cfg         (cfg_q),
		.push        (push),
		.push_job    (push_job),
		.queue_ready (queue_ready)
	);

	ctme_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (queue_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	ctme_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.cfg        (cfg_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_msg    (msg)
	);

	assign m_tdata = {1'b0, msg.value, msg.number, msg.channel};
	assign m_tuser = msg.kind;
	assign m_tlast = msg.last;

endmodule
